FILE: rtl/aem_pkg.sv
// aem_pkg: shared constants, codes and control structs of the AC energy meter.
// No dependencies; imported by aem_ctrl, aem_dp and ac_energy_meter_core.
package aem_pkg;

   localparam int SAMPLE_BITS_DEF = 10;
   localparam int VSUM_W = 40;
   localparam int ISUM_W = 56;
   localparam int PSUM_W = 56;
   localparam int CNT_W = 16;
   localparam int DIV_W = 56;
   localparam int DVS_W = 32;
   localparam int SQ_W = 56;
   localparam int ROOT_W = SQ_W / 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;
   localparam int GAIN_W = 20;
   localparam int GAIN_RESET = 65536;
   localparam int WINDOW_RESET = 1000;
   localparam int VRMS_W = 12;
   localparam int IRMS_W = 16;
   localparam int PF_W = 17;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_VOLTAGE_OFFSET = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_OFFSET = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VOLTAGE_RMS_OFFSET = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_RMS_OFFSET = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_POWER_OFFSET = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_CURRENT_GAIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_WINDOW = 3'd6;

   typedef enum logic [2:0] {
      MUL_CG, MUL_VV, MUL_II, MUL_VI, MUL_APP
   } aem_mul_type;

   typedef enum logic [1:0] {
      DIV_V, DIV_I, DIV_P, DIV_PF
   } aem_div_type;

   typedef struct packed {
      logic        mul_en;
      aem_mul_type mul_sel;
      logic        take_i;
      logic        acc_v;
      logic        acc_i;
      logic        acc_p;
      logic        div_start;
      aem_div_type div_sel;
      logic        sqrt_start;
      logic        cap_v;
      logic        cap_i;
      logic        cap_p;
      logic        cap_app;
      logic        pf_zero;
      logic        cap_pf;
      logic        publish;
   } aem_cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic win_end;
      logic pf_ok;
      logic out_full;
   } aem_status_type;

endpackage

FILE: rtl/aem_ctrl.sv
// aem_ctrl: sequencer of the energy meter; steps the datapath per request
// and through the window-end math. Depends on aem_pkg.
module aem_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  aem_pkg::aem_status_type status,
   output aem_pkg::aem_cmd_type    cmd
);
   import aem_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_MUL_GAIN, S_MUL_VV, S_MUL_II, S_MUL_VI, S_ACC_P, S_CHECK,
      S_DIV_V, S_DV_W, S_SQ_V, S_SV_W, S_DIV_I, S_DI_W, S_SQ_I, S_SI_W,
      S_DIV_P, S_DP_W, S_APP, S_APP_W, S_PF_CHK, S_DPF_W, S_PUB
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.mul_sel = MUL_CG;
      cmd.div_sel = DIV_V;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_MUL_GAIN;
         S_MUL_GAIN: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_CG; state_in = S_MUL_VV;
         end
         S_MUL_VV: begin
            cmd.take_i = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MUL_VV;
            state_in = S_MUL_II;
         end
         S_MUL_II: begin
            cmd.acc_v = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MUL_II;
            state_in = S_MUL_VI;
         end
         S_MUL_VI: begin
            cmd.acc_i = 1'b1; cmd.mul_en = 1'b1; cmd.mul_sel = MUL_VI;
            state_in = S_ACC_P;
         end
         S_ACC_P: begin
            cmd.acc_p = 1'b1; state_in = S_CHECK;
         end
         S_CHECK: state_in = status.win_end ? S_DIV_V : S_IDLE;
         S_DIV_V: begin
            cmd.div_start = 1'b1; cmd.div_sel = DIV_V; state_in = S_DV_W;
         end
         S_DV_W: if (!status.div_busy) state_in = S_SQ_V;
         S_SQ_V: begin
            cmd.sqrt_start = 1'b1; state_in = S_SV_W;
         end
         S_SV_W: if (!status.sqrt_busy) begin
            cmd.cap_v = 1'b1; state_in = S_DIV_I;
         end
         S_DIV_I: begin
            cmd.div_start = 1'b1; cmd.div_sel = DIV_I; state_in = S_DI_W;
         end
         S_DI_W: if (!status.div_busy) state_in = S_SQ_I;
         S_SQ_I: begin
            cmd.sqrt_start = 1'b1; state_in = S_SI_W;
         end
         S_SI_W: if (!status.sqrt_busy) begin
            cmd.cap_i = 1'b1; state_in = S_DIV_P;
         end
         S_DIV_P: begin
            cmd.div_start = 1'b1; cmd.div_sel = DIV_P; state_in = S_DP_W;
         end
         S_DP_W: if (!status.div_busy) begin
            cmd.cap_p = 1'b1; state_in = S_APP;
         end
         S_APP: begin
            cmd.mul_en = 1'b1; cmd.mul_sel = MUL_APP; state_in = S_APP_W;
         end
         S_APP_W: begin
            cmd.cap_app = 1'b1; state_in = S_PF_CHK;
         end
         S_PF_CHK: begin
            if (status.pf_ok) begin
               cmd.div_start = 1'b1; cmd.div_sel = DIV_PF; state_in = S_DPF_W;
            end else begin
               cmd.pf_zero = 1'b1; state_in = S_PUB;
            end
         end
         S_DPF_W: if (!status.div_busy) begin
            cmd.cap_pf = 1'b1; state_in = S_PUB;
         end
         S_PUB: if (!status.out_full) begin
            cmd.publish = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: rtl/aem_dp.sv
// aem_dp: energy meter datapath: config registers, shared multiplier,
// accumulators, radix-2 divider, bit-pair square root, result register.
// Depends on aem_pkg.
module aem_dp #(
   parameter int SAMPLE_BITS = aem_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_accept,
   input  logic [SAMPLE_BITS-1:0]               req_voltage_sample,
   input  logic [SAMPLE_BITS-1:0]               req_current_sample,
   input  logic                                 csr_we,
   input  logic [aem_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [aem_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  aem_pkg::aem_cmd_type                 cmd,
   output aem_pkg::aem_status_type              status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [aem_pkg::VRMS_W-1:0]           rsp_voltage_rms,
   output logic [aem_pkg::IRMS_W-1:0]           rsp_current_rms,
   output logic signed [31:0]                   rsp_real_power,
   output logic [31:0]                          rsp_apparent_power,
   output logic [aem_pkg::PF_W-1:0]             rsp_power_factor
);
   import aem_pkg::*;

   // centred sample: doubled offset-free sample plus a 10-bit offset
   localparam int SW = ((SAMPLE_BITS + 1 > 10) ? SAMPLE_BITS + 1 : 10) + 1;
   localparam int IW = SW + 5;
   localparam int MW = (IW > GAIN_W + 1) ? IW : GAIN_W + 1;
   localparam int PW = 2 * MW;
   localparam int MID = 1 << (SAMPLE_BITS - 1);

   // configuration
   logic signed [9:0]  voff_ff, ioff_ff;
   logic signed [10:0] vroff_ff;
   logic signed [15:0] iroff_ff, poff_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [CNT_W-1:0]   win_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         voff_ff <= '0; ioff_ff <= '0; vroff_ff <= '0;
         iroff_ff <= '0; poff_ff <= '0;
         gain_ff <= GAIN_W'(GAIN_RESET);
         win_ff <= CNT_W'(WINDOW_RESET);
      end else if (csr_we) begin
         case (csr_index)
            REG_VOLTAGE_OFFSET:     voff_ff <= csr_wdata[9:0];
            REG_CURRENT_OFFSET:     ioff_ff <= csr_wdata[9:0];
            REG_VOLTAGE_RMS_OFFSET: vroff_ff <= csr_wdata[10:0];
            REG_CURRENT_RMS_OFFSET: iroff_ff <= csr_wdata[15:0];
            REG_POWER_OFFSET:       poff_ff <= csr_wdata[15:0];
            REG_CURRENT_GAIN:       gain_ff <= csr_wdata;
            REG_SAMPLE_WINDOW:      win_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // centring
   logic signed [SW-1:0] v_cen, c_cen, v_ff, c_ff;
   logic signed [IW-1:0] i_ff;

   always_comb begin
      v_cen = ((SW'($signed({1'b0, req_voltage_sample})) - SW'(MID)) <<< 1)
              + SW'(voff_ff);
      c_cen = ((SW'($signed({1'b0, req_current_sample})) - SW'(MID)) <<< 1)
              + SW'(ioff_ff);
   end

   // shared multiplier, registered product
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod_ff;
   logic signed [63:0]   prod_x;
   logic [VRMS_W-1:0]    vr_ff;
   logic [IRMS_W-1:0]    ir_ff;

   always_comb begin
      case (cmd.mul_sel)
         MUL_CG:  begin mul_a = MW'(c_ff); mul_b = MW'($signed({1'b0, gain_ff})); end
         MUL_VV:  begin mul_a = MW'(v_ff); mul_b = MW'(v_ff); end
         MUL_II:  begin mul_a = MW'(i_ff); mul_b = MW'(i_ff); end
         MUL_VI:  begin mul_a = MW'(v_ff); mul_b = MW'(i_ff); end
         MUL_APP: begin
            mul_a = MW'($signed({1'b0, vr_ff}));
            mul_b = MW'($signed({1'b0, ir_ff}));
         end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
      prod_x = 64'(prod_ff);
   end

   // accumulators
   logic [VSUM_W-1:0] vsum_ff;
   logic [ISUM_W-1:0] isum_ff;
   logic [PSUM_W-1:0] psum_ff;
   logic [CNT_W-1:0]  cnt_ff, win_eff;

   assign win_eff = (win_ff == '0) ? CNT_W'(1) : win_ff;

   // divider
   logic [DIV_W-1:0] quo_ff, dvd;
   logic [DVS_W:0]   drem_ff, dtrial;
   logic [DVS_W-1:0] dvs_ff, dvs;
   logic [5:0]       dcnt_ff;
   logic             div_busy_ff;
   logic [PSUM_W-1:0] psum_mag;

   // square root
   logic [SQ_W-1:0]   sx_ff;
   logic [ROOT_W+2:0] srem_ff, strial, sr;
   logic [ROOT_W-1:0] root_ff;
   logic [4:0]        scnt_ff;
   logic              sqrt_busy_ff;

   // results
   logic signed [31:0] real_ff;
   logic [31:0]        app_ff;
   logic [PF_W-1:0]    pf_ff;
   logic               neg_ff;
   logic signed [ROOT_W+1:0] vr_sum, ir_sum;
   logic signed [PSUM_W+1:0] real_sum;

   always_comb begin
      psum_mag = psum_ff[PSUM_W-1] ? (~psum_ff + PSUM_W'(1)) : psum_ff;
      case (cmd.div_sel)
         DIV_V:  begin dvd = DIV_W'(vsum_ff); dvs = DVS_W'(cnt_ff); end
         DIV_I:  begin dvd = DIV_W'(isum_ff); dvs = DVS_W'(cnt_ff); end
         DIV_P:  begin dvd = DIV_W'(psum_mag); dvs = DVS_W'(cnt_ff); end
         DIV_PF: begin dvd = DIV_W'({real_ff[30:0], 16'h0000}); dvs = app_ff; end
         default: begin dvd = '0; dvs = '0; end
      endcase
      dtrial = {drem_ff[DVS_W-1:0], quo_ff[DIV_W-1]};
      sr = {srem_ff[ROOT_W:0], sx_ff[SQ_W-1 -: 2]};
      strial = (ROOT_W+3)'({root_ff, 2'b01});
      vr_sum = $signed({2'b00, root_ff}) + (ROOT_W+2)'(vroff_ff);
      ir_sum = $signed({2'b00, root_ff}) + (ROOT_W+2)'(iroff_ff);
      real_sum = (neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff}))
                 + (PSUM_W+2)'(poff_ff);
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         v_ff <= v_cen;
         c_ff <= c_cen;
      end
      if (cmd.mul_en) prod_ff <= PW'(mul_a * mul_b);
      if (cmd.take_i) i_ff <= prod_ff[16 +: IW];
      if (cmd.div_start) begin
         quo_ff <= dvd;
         dvs_ff <= dvs;
         drem_ff <= '0;
         dcnt_ff <= 6'(DIV_W);
         neg_ff <= (cmd.div_sel == DIV_P) && psum_ff[PSUM_W-1];
      end else if (div_busy_ff) begin
         if (dtrial >= {1'b0, dvs_ff}) begin
            drem_ff <= dtrial - {1'b0, dvs_ff};
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            drem_ff <= dtrial;
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - 6'd1;
      end
      if (cmd.sqrt_start) begin
         sx_ff <= quo_ff;
         srem_ff <= '0;
         root_ff <= '0;
         scnt_ff <= 5'(ROOT_W);
      end else if (sqrt_busy_ff) begin
         if (sr >= strial) begin
            srem_ff <= sr - strial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            srem_ff <= sr;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
         sx_ff <= {sx_ff[SQ_W-3:0], 2'b00};
         scnt_ff <= scnt_ff - 5'd1;
      end
      if (cmd.cap_v) begin
         if (vr_sum < 0) vr_ff <= '0;
         else if (vr_sum > (ROOT_W+2)'(4095)) vr_ff <= '1;
         else vr_ff <= vr_sum[VRMS_W-1:0];
      end
      if (cmd.cap_i) begin
         if (ir_sum < 0) ir_ff <= '0;
         else if (ir_sum > (ROOT_W+2)'(65535)) ir_ff <= '1;
         else ir_ff <= ir_sum[IRMS_W-1:0];
      end
      if (cmd.cap_p) begin
         if (real_sum < -(PSUM_W+2)'(64'sh80000000)) real_ff <= 32'sh80000000;
         else if (real_sum > (PSUM_W+2)'(64'sh7FFFFFFF)) real_ff <= 32'sh7FFFFFFF;
         else real_ff <= real_sum[31:0];
      end
      if (cmd.cap_app) app_ff <= prod_ff[31:0];
      if (cmd.pf_zero) pf_ff <= '0;
      if (cmd.cap_pf) pf_ff <= quo_ff[PF_W-1:0];
      if (cmd.publish) begin
         rsp_voltage_rms <= vr_ff;
         rsp_current_rms <= ir_ff;
         rsp_real_power <= real_ff;
         rsp_apparent_power <= app_ff;
         rsp_power_factor <= pf_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         vsum_ff <= '0; isum_ff <= '0; psum_ff <= '0; cnt_ff <= '0;
         div_busy_ff <= 1'b0; sqrt_busy_ff <= 1'b0; rsp_valid <= 1'b0;
      end else begin
         if (cmd.acc_v) vsum_ff <= vsum_ff + prod_x[VSUM_W-1:0];
         if (cmd.acc_i) isum_ff <= isum_ff + prod_x[ISUM_W-1:0];
         if (cmd.acc_p) begin
            psum_ff <= psum_ff + prod_x[PSUM_W-1:0];
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.publish) begin
            vsum_ff <= '0; isum_ff <= '0; psum_ff <= '0; cnt_ff <= '0;
         end
         if (cmd.div_start) div_busy_ff <= 1'b1;
         else if (div_busy_ff && dcnt_ff == 6'd1) div_busy_ff <= 1'b0;
         if (cmd.sqrt_start) sqrt_busy_ff <= 1'b1;
         else if (sqrt_busy_ff && scnt_ff == 5'd1) sqrt_busy_ff <= 1'b0;
         if (cmd.publish) rsp_valid <= 1'b1;
         else if (rsp_ready) rsp_valid <= 1'b0;
      end
   end

   always_comb begin
      status.div_busy = div_busy_ff;
      status.sqrt_busy = sqrt_busy_ff;
      status.win_end = (cnt_ff >= win_eff);
      status.pf_ok = (app_ff != '0) && !real_ff[31] && ({1'b0, real_ff[30:0]} <= app_ff);
      status.out_full = rsp_valid && !rsp_ready;
   end

`ifndef ASSERT_OFF
   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(div_busy_ff && sqrt_busy_ff)) else $error("divider and root overlap");
   a_publish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |=> rsp_valid) else $error("publish lost");
   a_pf_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_power_factor <= PF_W'(65536)) else $error("pf above one");
   a_pf_zero_app: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_apparent_power == '0) |-> rsp_power_factor == '0)
      else $error("pf with zero apparent power");
`endif

endmodule

FILE: rtl/ac_energy_meter_core.sv
// ac_energy_meter_core: top level of the windowed RMS and power meter.
// Depends on aem_pkg, aem_ctrl and aem_dp.
//
//  channel  | direction | handshake          | payload
//  req      | in        | req_valid/ready    | voltage_sample, current_sample
//  rsp      | out       | rsp_valid/ready    | rms V/I, real, apparent, pf
//  csr      | in        | csr_we (no wait)   | csr_index, csr_wdata
//
// A request that does not close a window goes through centring, four
// passes through the one shared multiplier, the last accumulate and the count check.
// A window-closing request adds three or four 56-step divisions (the pf one only when
// pf is in range) and two 28-step square roots on the shared radix-2 units.
// Synchronous active-high reset clears sums, count and configuration registers to defaults.
// A finished result sits in the output register; the next request is taken
// while it waits, and only the following window end stalls on it.
module ac_energy_meter_core #(
   parameter int SAMPLE_BITS = aem_pkg::SAMPLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [SAMPLE_BITS-1:0]             req_voltage_sample,
   input  logic [SAMPLE_BITS-1:0]             req_current_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [aem_pkg::VRMS_W-1:0]         rsp_voltage_rms,
   output logic [aem_pkg::IRMS_W-1:0]         rsp_current_rms,
   output logic signed [31:0]                 rsp_real_power,
   output logic [31:0]                        rsp_apparent_power,
   output logic [aem_pkg::PF_W-1:0]           rsp_power_factor,
   input  logic                               csr_we,
   input  logic [aem_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [aem_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import aem_pkg::*;

   aem_cmd_type    cmd;
   aem_status_type status;
   logic           req_accept;

   // sample is centred straight into the datapath on the accepting edge
   assign req_accept = req_valid && req_ready;

   aem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aem_dp #(.SAMPLE_BITS(SAMPLE_BITS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_accept         (req_accept),
      .req_voltage_sample (req_voltage_sample),
      .req_current_sample (req_current_sample),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_voltage_rms    (rsp_voltage_rms),
      .rsp_current_rms    (rsp_current_rms),
      .rsp_real_power     (rsp_real_power),
      .rsp_apparent_power (rsp_apparent_power),
      .rsp_power_factor   (rsp_power_factor)
   );

endmodule
